// ----- design/wchbf_pkg.sv -----
package wchbf_pkg;

    localparam int BIN_COUNT  = 128;
    localparam int COUNT_BITS = 24;
    localparam int BIN_BITS   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

    localparam int WEIGHT_BITS = 7;
    localparam int BAND_BITS   = 17;
    localparam int COLOR_BITS  = 8;
    localparam int IDX_BITS    = 7;
    localparam int REQ_BITS    = 2;
    localparam int SUM_BITS    = 9;
    localparam int CH_BITS     = 17;
    localparam int NUM_BITS    = CH_BITS + BIN_BITS;

    localparam int OUT_COUNT_BITS = 24;
    localparam int OUT_BIN_BITS   = 7;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 17;

    localparam int S_TDATA_BITS = 32;
    localparam int M_TDATA_BITS = 56;

    localparam int COLOR_MAX     = 255;
    localparam int DEN_ZERO_SUM  = 100;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET    = WEIGHT_BITS'(100);
    localparam logic [BAND_BITS-1:0]   BAND_LOW_RESET  = BAND_BITS'(0);
    localparam logic [BAND_BITS-1:0]   BAND_HIGH_RESET = BAND_BITS'(76500);

    localparam logic [REQ_BITS-1:0] REQ_POINT = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_NOP   = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_RED   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_GREEN = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_BLUE  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND_LOW     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND_HIGH    = 3'd4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                  rd_en;
        logic [BIN_BITS-1:0]   rd_addr;
        logic                  wr_en;
        logic [BIN_BITS-1:0]   wr_addr;
        logic [COUNT_BITS-1:0] wr_data;
        logic                  clear;
    } bin_req_t;

    typedef struct packed {
        logic                done;
        logic [BIN_BITS-1:0] quot;
    } div_res_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

// ----- design/weighted_color_histogram_band_filter.sv -----
// weighted color band filter with a running histogram
// input stream s_*: one request per transfer, kind in s_tuser, color and bin index in s_tdata
//   point: forms the weighted color sum, flags it visible inside the band, counts the point
//   into its histogram bin and bumps the kept count when visible
//   read: returns the count of one bin and the kept count; clear: zeros all bins and kept count
// result stream m_*: exactly one result transfer per request, in request order
// configuration: cfg_wr_en writes cfg_data to register cfg_index, idle block only
// path to m_tvalid: a point goes through start, divide, read and update (the divider skips
//   its bit steps when the sum clamps to the top bin), a read through read and update,
//   clear and no-op straight to update; the block takes one request at a time, and the
//   bin divider retires one quotient bit per cycle (7 bit steps for 128 bins) ahead of
//   the bin memory read and its write back
// the result sits in an output register, so a stalled receiver holds m_tdata while the
//   block already takes and works on the next request; the block waits at the update step
//   (bin write back or clear) only when that register is still full
// reset: synchronous active-low aresetn zeros all bins (per-bin valid bits) and the kept
//   count at once, loads default weights and band, and drops m_tvalid
module weighted_color_histogram_band_filter
    import wchbf_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // red[7:0], green[15:8], blue[23:16], bin_index[30:24]
    input  logic [S_TDATA_BITS-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [REQ_BITS-1:0]       s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // visible[0], bin_count[24:1], kept_count[48:25], point_bin[55:49]
    output logic [M_TDATA_BITS-1:0]   m_tdata,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_READ,
        S_UPDATE
    } state_t;

    state_t state_reg;

    logic [WEIGHT_BITS-1:0] weight_red_reg;
    logic [WEIGHT_BITS-1:0] weight_green_reg;
    logic [WEIGHT_BITS-1:0] weight_blue_reg;
    logic [BAND_BITS-1:0]   band_low_reg;
    logic [BAND_BITS-1:0]   band_high_reg;

    logic [REQ_BITS-1:0]    req_reg;
    logic [CH_BITS-1:0]     ch_reg;
    logic [CH_BITS-1:0]     den_reg;
    logic [BIN_BITS-1:0]    addr_reg;
    logic                   addr_ok_reg;
    logic                   vis_reg;
    logic [COUNT_BITS-1:0]  kept_reg;

    logic                   m_valid_reg;
    logic                   out_vis_reg;
    logic [COUNT_BITS-1:0]  out_cnt_reg;
    logic [COUNT_BITS-1:0]  out_kept_reg;
    logic [BIN_BITS-1:0]    out_bin_reg;

    logic [COLOR_BITS-1:0]  in_red;
    logic [COLOR_BITS-1:0]  in_green;
    logic [COLOR_BITS-1:0]  in_blue;
    logic [IDX_BITS-1:0]    in_idx;
    logic                   in_xfer;
    logic [CH_BITS-1:0]     prod_red;
    logic [CH_BITS-1:0]     prod_green;
    logic [CH_BITS-1:0]     prod_blue;
    logic [SUM_BITS-1:0]    weight_sum;
    logic [CH_BITS-1:0]     ch_calc;
    logic [CH_BITS-1:0]     den_calc;

    logic                   out_free;
    logic [COUNT_BITS-1:0]  bin_rd_data;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [COUNT_BITS-1:0]  kept_upd;
    bin_req_t               bins_ctrl;
    div_res_t               div_res;

    assign in_red   = s_tdata[7:0];
    assign in_green = s_tdata[15:8];
    assign in_blue  = s_tdata[23:16];
    assign in_idx   = s_tdata[30:24];

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    assign prod_red   = CH_BITS'(weight_red_reg) * CH_BITS'(in_red);
    assign prod_green = CH_BITS'(weight_green_reg) * CH_BITS'(in_green);
    assign prod_blue  = CH_BITS'(weight_blue_reg) * CH_BITS'(in_blue);
    assign ch_calc    = prod_red + prod_green + prod_blue;
    assign weight_sum = SUM_BITS'(weight_red_reg) + SUM_BITS'(weight_green_reg)
                      + SUM_BITS'(weight_blue_reg);
    assign den_calc   = (weight_sum == '0) ? CH_BITS'(DEN_ZERO_SUM)
                      : CH_BITS'(weight_sum) * CH_BITS'(COLOR_MAX);

    assign out_free = !m_valid_reg || m_tready;
    assign cnt_inc  = sat_inc(bin_rd_data);
    assign kept_upd = vis_reg ? sat_inc(kept_reg) : kept_reg;

    always_comb begin
        bins_ctrl.rd_en   = (state_reg == S_READ) && addr_ok_reg;
        bins_ctrl.rd_addr = addr_reg;
        bins_ctrl.wr_en   = (state_reg == S_UPDATE) && out_free && (req_reg == REQ_POINT);
        bins_ctrl.wr_addr = addr_reg;
        bins_ctrl.wr_data = cnt_inc;
        bins_ctrl.clear   = (state_reg == S_UPDATE) && out_free && (req_reg == REQ_CLEAR);
    end

    wchbf_bins u_bins (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (bins_ctrl),
        .rd_data (bin_rd_data)
    );

    wchbf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_START),
        .ch      (ch_reg),
        .den     (den_reg),
        .res     (div_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_red_reg   <= WEIGHT_RESET;
            weight_green_reg <= WEIGHT_RESET;
            weight_blue_reg  <= WEIGHT_RESET;
            band_low_reg     <= BAND_LOW_RESET;
            band_high_reg    <= BAND_HIGH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WEIGHT_RED:   weight_red_reg   <= cfg_data[WEIGHT_BITS-1:0];
                CFG_WEIGHT_GREEN: weight_green_reg <= cfg_data[WEIGHT_BITS-1:0];
                CFG_WEIGHT_BLUE:  weight_blue_reg  <= cfg_data[WEIGHT_BITS-1:0];
                CFG_BAND_LOW:     band_low_reg     <= cfg_data[BAND_BITS-1:0];
                CFG_BAND_HIGH:    band_high_reg    <= cfg_data[BAND_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            kept_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready && !((state_reg == S_UPDATE) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        req_reg     <= s_tuser;
                        ch_reg      <= ch_calc;
                        den_reg     <= den_calc;
                        addr_reg    <= BIN_BITS'(in_idx);
                        addr_ok_reg <= (int'(in_idx) < BIN_COUNT) || (s_tuser == REQ_POINT);
                        case (s_tuser)
                            REQ_POINT: state_reg <= S_START;
                            REQ_READ:  state_reg <= S_READ;
                            default:   state_reg <= S_UPDATE;
                        endcase
                    end
                end
                S_START: begin
                    vis_reg   <= (ch_reg >= band_low_reg) && (ch_reg <= band_high_reg);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_res.done) begin
                        addr_reg  <= div_res.quot;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                        case (req_reg)
                            REQ_POINT: begin
                                out_vis_reg  <= vis_reg;
                                out_cnt_reg  <= cnt_inc;
                                out_kept_reg <= kept_upd;
                                out_bin_reg  <= addr_reg;
                                kept_reg     <= kept_upd;
                            end
                            REQ_READ: begin
                                out_vis_reg  <= 1'b0;
                                out_cnt_reg  <= addr_ok_reg ? bin_rd_data : '0;
                                out_kept_reg <= kept_reg;
                                out_bin_reg  <= '0;
                            end
                            REQ_CLEAR: begin
                                out_vis_reg  <= 1'b0;
                                out_cnt_reg  <= '0;
                                out_kept_reg <= '0;
                                out_bin_reg  <= '0;
                                kept_reg     <= '0;
                            end
                            default: begin
                                out_vis_reg  <= 1'b0;
                                out_cnt_reg  <= '0;
                                out_kept_reg <= '0;
                                out_bin_reg  <= '0;
                            end
                        endcase
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {OUT_BIN_BITS'(out_bin_reg), OUT_COUNT_BITS'(out_kept_reg),
                       OUT_COUNT_BITS'(out_cnt_reg), out_vis_reg};

`ifndef SYNTH
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider result outside divide wait");

    a_write_point_only: assert property (@(posedge aclk) disable iff (!aresetn)
        bins_ctrl.wr_en |-> (state_reg == S_UPDATE) && (req_reg == REQ_POINT)
                            && !bins_ctrl.rd_en)
        else $error("bin write outside point update");

    a_result_from_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_UPDATE))
        else $error("result raised outside update");

    a_kept_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (kept_reg != $past(kept_reg))
            |-> (kept_reg == $past(kept_reg) + 1'b1) || (kept_reg == '0))
        else $error("kept count jumped");
`endif

endmodule

// ----- design/wchbf_bins.sv -----
module wchbf_bins
    import wchbf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bin_req_t              ctrl,
    output logic [COUNT_BITS-1:0] rd_data
);

    logic [COUNT_BITS-1:0] mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]  valid_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    // entries never written since reset or clear read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctrl.wr_en) begin
                valid_reg[ctrl.wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                rd_valid_reg <= valid_reg[ctrl.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- design/wchbf_div.sv -----
module wchbf_div
    import wchbf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [CH_BITS-1:0] ch,
    input  logic [CH_BITS-1:0] den,
    output div_res_t           res
);

    localparam int STEP_BITS = $clog2(BIN_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [CH_BITS-1:0]   rem_reg;
    logic [CH_BITS-1:0]   den_reg;
    logic [BIN_BITS-1:0]  low_reg;
    logic [BIN_BITS-1:0]  quot_reg;

    logic [NUM_BITS-1:0]  num;
    logic [CH_BITS:0]     trial;
    logic [CH_BITS:0]     diff;
    logic                 take;

    assign num   = NUM_BITS'(ch) * NUM_BITS'(BIN_COUNT);
    assign trial = {rem_reg, low_reg[BIN_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            den_reg <= den;
            // quotient of bin_count or more clamps to the top bin
            if (ch >= den) begin
                quot_reg <= BIN_BITS'(BIN_COUNT - 1);
                done_reg <= 1'b1;
                busy_reg <= 1'b0;
            end else begin
                quot_reg <= '0;
                rem_reg  <= num[NUM_BITS-1:BIN_BITS];
                low_reg  <= num[BIN_BITS-1:0];
                step_reg <= STEP_BITS'(BIN_BITS);
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
        end else if (busy_reg) begin
            rem_reg  <= take ? diff[CH_BITS-1:0] : trial[CH_BITS-1:0];
            low_reg  <= low_reg << 1;
            quot_reg <= (quot_reg << 1) | BIN_BITS'(take);
            step_reg <= step_reg - 1'b1;
            busy_reg <= (step_reg != STEP_BITS'(1));
            done_reg <= (step_reg == STEP_BITS'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule
